>>> src/mldc_pkg.sv
package mldc_pkg;

  // Fixed field widths of the stream payloads
  localparam int LIST_INDEX_W    = 4;
  localparam int PUSH_VALUE_W    = 32;
  localparam int ELEM_VALUE_W    = 32;
  localparam int ELEM_POS_W      = 5;
  localparam int LISTS_IN_USE_W  = 5;
  localparam int S_TDATA_W       = 40;
  localparam int M_TDATA_W       = 40;

  // Lists reachable through the list_index field
  localparam int MAX_ADDRESSABLE = 1 << LIST_INDEX_W;

  localparam logic [LISTS_IN_USE_W-1:0] LISTS_IN_USE_RESET = 5'd16;

  // Result queue between element RAM and master port
  localparam int OUTQ_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_DUMP  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  typedef struct packed {
    logic [ELEM_VALUE_W-1:0] value;
    logic [ELEM_POS_W-1:0]   pos;
    logic                    last;
    logic                    empty;
    logic                    ovf;
  } out_item_t;

endpackage

>>> src/mldc_elem_ram.sv
module mldc_elem_ram #(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/mldc_out_fifo.sv
module mldc_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mldc_pkg::out_item_t push_item,
  input  logic                pop,
  output logic [1:0]          count,
  output logic                valid,
  output mldc_pkg::out_item_t head
);

  mldc_pkg::out_item_t slots [mldc_pkg::OUTQ_DEPTH];
  logic                wr_ptr;
  logic                rd_ptr;

  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

>>> src/multi_list_append_dump_clear.sv
// Channel | Signals                              | Transfer moves
// --------+--------------------------------------+------------------------------------
// s       | s_tvalid s_tready s_tdata s_tuser    | one command (push, dump, clear)
// m       | m_tvalid m_tready m_tdata m_tuser    | one dumped element, m_tlast on last
//         | m_tlast                              |
// cfg     | cfg_valid cfg_ready cfg_data         | lists_in_use register write
//
// Push, clear and ignored commands do not hold off the input.
// A dump of n elements holds off the input: after the command is taken,
// s_tready stays low while max(n,1) element RAM reads are issued; results
// leave through the RAM's registered port and a 2-entry queue, which keeps
// one result per cycle going while m_tready stays high.
// Reset (rst, synchronous) clears list lengths and overflow flags at once;
// the element RAM is not cleared, so no clearing pass is needed.
// A stall on m pauses RAM reads through the queue credit check only.
module multi_list_append_dump_clear #(
  parameter int NUM_LISTS     = 16,
  parameter int LIST_CAPACITY = 32,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mldc_pkg::S_TDATA_W-1:0] s_tdata,  // [3:0] list_index, [35:4] push_value,
                                                   // [39:36] zero
  input  logic [1:0]                     s_tuser,  // [1:0] command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mldc_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] element_value,
                                                   // [36:32] element_position,
                                                   // [39:37] zero
  output logic [1:0]                     m_tuser,  // [0] list_empty, [1] overflowed
  output logic                           m_tlast,  // is_last
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [4:0]                     cfg_data  // lists_in_use
);

  // Only lists reachable through the 4-bit index need metadata and RAM rows
  localparam int LISTS_EFF = (NUM_LISTS < mldc_pkg::MAX_ADDRESSABLE) ?
                             NUM_LISTS : mldc_pkg::MAX_ADDRESSABLE;
  localparam int IDX_W  = (LISTS_EFF > 1) ? $clog2(LISTS_EFF) : 1;
  localparam int POS_W  = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int LEN_W  = $clog2(LIST_CAPACITY + 1);
  localparam int ADDR_W = IDX_W + POS_W;

  // Registers
  logic [mldc_pkg::LISTS_IN_USE_W-1:0] lists_in_use;
  logic [LEN_W-1:0]                    meta_len [LISTS_EFF];
  logic                                meta_ovf [LISTS_EFF];
  mldc_pkg::state_t                    state;
  mldc_pkg::state_t                    state_next;
  logic [IDX_W-1:0]                    cur_idx;
  logic [LEN_W-1:0]                    cur_len;
  logic                                cur_ovf;
  logic [LEN_W-1:0]                    pos;
  logic                                rd_valid;
  logic [LEN_W-1:0]                    rd_pos;
  logic                                rd_last;
  logic                                rd_empty;
  logic                                rd_ovf;

  // Input decode
  mldc_pkg::cmd_t                          cmd;
  logic [mldc_pkg::LIST_INDEX_W-1:0]       idx_in;
  logic [mldc_pkg::PUSH_VALUE_W-1:0]       push_value;
  logic                                    in_xfer;
  logic                                    idx_ok;
  logic [IDX_W-1:0]                        sel;

  assign cmd        = mldc_pkg::cmd_t'(s_tuser);
  assign idx_in     = s_tdata[3:0];
  assign push_value = s_tdata[35:4];
  assign in_xfer    = s_tvalid && s_tready;
  assign idx_ok     = ({1'b0, idx_in} < lists_in_use) &&
                      ({28'd0, idx_in} < 32'(NUM_LISTS));
  assign sel        = idx_in[IDX_W-1:0];

  // Datapath
  logic [LEN_W-1:0]       sel_len;
  logic                   sel_full;
  logic                   do_push;
  logic                   do_clear;
  logic                   do_dump;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   issue;
  logic                   issue_last;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_q;
  logic [1:0]             q_count;
  logic                   q_pop;
  logic                   can_issue;
  mldc_pkg::out_item_t    q_in;
  mldc_pkg::out_item_t    q_head;

  assign sel_len  = meta_len[sel];
  assign sel_full = (sel_len >= LEN_W'(LIST_CAPACITY));
  assign do_push  = in_xfer && idx_ok && (cmd == mldc_pkg::CMD_PUSH);
  assign do_clear = in_xfer && idx_ok && (cmd == mldc_pkg::CMD_CLEAR);
  assign do_dump  = in_xfer && idx_ok && (cmd == mldc_pkg::CMD_DUMP);

  // Append goes straight to the RAM; no read can target it in the same cycle
  // since reads are issued only while the input is held off.
  assign ram_we    = do_push && !sel_full;
  assign ram_waddr = {sel, sel_len[POS_W-1:0]};
  assign ram_wdata = VALUE_WIDTH'($signed(push_value));

  // No transfer is taken while reset is held
  assign s_tready  = !rst && (state == mldc_pkg::ST_IDLE);
  assign cfg_ready = !rst;

  // Read only when the queue will have room when the data lands
  assign q_pop     = m_tvalid && m_tready;
  assign can_issue = ({1'b0, q_count} + {2'b00, rd_valid}) <
                     (3'(mldc_pkg::OUTQ_DEPTH) + {2'b00, q_pop});
  assign issue_last = (cur_len == '0) || (LEN_W'(pos + 1'b1) == cur_len);
  assign ram_raddr  = {cur_idx, pos[POS_W-1:0]};

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    case (state)
      mldc_pkg::ST_IDLE: begin
        if (do_dump) begin
          state_next = mldc_pkg::ST_DUMP;
        end
      end
      mldc_pkg::ST_DUMP: begin
        issue = can_issue;
        if (can_issue && issue_last) begin
          state_next = mldc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mldc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mldc_pkg::ST_IDLE;
      lists_in_use <= mldc_pkg::LISTS_IN_USE_RESET;
      rd_valid     <= 1'b0;
      for (int i = 0; i < LISTS_EFF; i++) begin
        meta_len[i] <= '0;
        meta_ovf[i] <= 1'b0;
      end
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (cfg_valid && cfg_ready) begin
        lists_in_use <= cfg_data;
      end
      if (do_push) begin
        if (sel_full) begin
          meta_ovf[sel] <= 1'b1;
        end else begin
          meta_len[sel] <= LEN_W'(sel_len + 1'b1);
        end
      end
      if (do_clear) begin
        meta_len[sel] <= '0;
        meta_ovf[sel] <= 1'b0;
      end
    end
  end

  // Dump context and read-stage payload
  always_ff @(posedge clk) begin
    if (do_dump) begin
      cur_idx <= sel;
      cur_len <= sel_len;
      cur_ovf <= meta_ovf[sel];
      pos     <= '0;
    end else if (issue) begin
      pos <= LEN_W'(pos + 1'b1);
    end
    if (issue) begin
      rd_pos   <= pos;
      rd_last  <= issue_last;
      rd_empty <= (cur_len == '0);
      rd_ovf   <= cur_ovf;
    end
  end

  mldc_elem_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Empty dump shows zero value and position
  always_comb begin
    q_in.value = rd_empty ? '0 : mldc_pkg::ELEM_VALUE_W'($signed(ram_q));
    q_in.pos   = rd_empty ? '0 : mldc_pkg::ELEM_POS_W'(rd_pos);
    q_in.last  = rd_last;
    q_in.empty = rd_empty;
    q_in.ovf   = rd_ovf;
  end

  mldc_out_fifo u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (rd_valid),
    .push_item (q_in),
    .pop       (q_pop),
    .count     (q_count),
    .valid     (m_tvalid),
    .head      (q_head)
  );

  assign m_tdata = {3'b000, q_head.pos, q_head.value};
  assign m_tuser = {q_head.ovf, q_head.empty};
  assign m_tlast = q_head.last;

`ifndef SYNTHESIS
  // Landing read data must always find a free queue slot
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (q_count < 2'(mldc_pkg::OUTQ_DEPTH) || q_pop))
    else $error("result queue overrun");

  // Read pointer stays inside the list being dumped
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mldc_pkg::ST_DUMP && cur_len != '0) |-> (pos < cur_len))
    else $error("dump read past list end");

  // A clear leaves its list empty
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    do_clear |=> (meta_len[$past(sel)] == '0 && !meta_ovf[$past(sel)]))
    else $error("clear did not empty list");
`endif

endmodule

>>> tb/multi_list_append_dump_clear_test.sv
`timescale 1ns / 100ps

module multi_list_append_dump_clear_test;

  localparam int NUM_LISTS     = 16;
  localparam int LIST_CAPACITY = 32;
  localparam int VALUE_WIDTH   = 32;

  // Command code 3 has no operation behind it; the block must drop it.
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  // Cycles without any transfer on s, m or cfg before the run is called hung.
  localparam int QUIET_LIMIT = 4000;
  // Cycles allowed after the last result for pushes/clears still in the pipe.
  localparam int SETTLE_CYCLES = 8;

  // One command as it travels on the s channel.
  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  index;
    logic [31:0] value;
  } list_op_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;   // [3:0] list_index, [35:4] push_value, [39:36] zero
  logic [1:0]  s_tuser   = '0;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;          // [31:0] element_value, [36:32] element_position,
                                 // [39:37] zero
  logic [1:0]  m_tuser;          // [0] list_empty, [1] overflowed
  logic        m_tlast;          // is_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data  = '0;   // lists_in_use

  // Commands waiting to go out on s, filled by the sequence below.
  list_op_t pending_ops_q[$];
  // Dump results predicted but not yet seen on m, oldest first.
  mldc_pkg::out_item_t dump_expect_q[$];

  // Shadow copy of the lists, kept in step with every accepted command.
  logic [VALUE_WIDTH-1:0] list_mem [NUM_LISTS][LIST_CAPACITY];
  int unsigned            fill_count [NUM_LISTS];
  bit                     overflow_seen [NUM_LISTS];
  logic [4:0]             active_lists = mldc_pkg::LISTS_IN_USE_RESET;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;

  multi_list_append_dump_clear #(
    .NUM_LISTS    (NUM_LISTS),
    .LIST_CAPACITY(LIST_CAPACITY),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Update the shadow lists for one accepted command and queue the results
  // a dump must produce. Commands to lists at or above lists_in_use, and
  // the reserved code, leave everything untouched.
  task automatic apply_list_op(input logic [1:0] command, input logic [3:0] index,
                               input logic [31:0] value);
    mldc_pkg::out_item_t res;
    int unsigned         len;
    if (index >= active_lists || index >= NUM_LISTS) return;
    len = fill_count[index];
    case (command)
      mldc_pkg::CMD_PUSH: begin
        // full list: value dropped, sticky flag set
        if (len >= LIST_CAPACITY) begin
          overflow_seen[index] = 1'b1;
        end else begin
          list_mem[index][len] = VALUE_WIDTH'($signed(value));
          fill_count[index]    = len + 1;
        end
      end
      mldc_pkg::CMD_CLEAR: begin
        fill_count[index]    = 0;
        overflow_seen[index] = 1'b0;
      end
      mldc_pkg::CMD_DUMP: begin
        if (len == 0) begin
          // empty list: one zero result marked both last and empty
          res = '{value: '0, pos: '0, last: 1'b1, empty: 1'b1,
                  ovf: overflow_seen[index]};
          dump_expect_q.insert(dump_expect_q.size(), res);
        end else begin
          for (int j = 0; j < len; j++) begin
            res = '{value: mldc_pkg::ELEM_VALUE_W'($signed(list_mem[index][j])),
                    pos:   mldc_pkg::ELEM_POS_W'(j),
                    last:  (j == len - 1),
                    empty: 1'b0,
                    ovf:   overflow_seen[index]};
            dump_expect_q.insert(dump_expect_q.size(), res);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Sender: a new command goes out whenever the slot is free, unless this
  // cycle is picked as a gap. Prediction happens at the accepting edge.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_list_op(s_tuser, s_tdata[3:0], s_tdata[35:4]);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ops_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tuser  <= pending_ops_q[0].command;
          s_tdata  <= {4'b0, pending_ops_q[0].value, pending_ops_q[0].index};
          void'(pending_ops_q.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure, each result checked against the oldest
  // prediction field by field.
  always @(posedge clk) begin : result_check
    mldc_pkg::out_item_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (dump_expect_q.size() == 0) begin
          $error("unexpected result: element_value %0d element_position %0d",
                 $signed(m_tdata[31:0]), m_tdata[36:32]);
          error_count++;
        end else begin
          want = dump_expect_q.pop_front();
          if (m_tdata[31:0] !== want.value) begin
            $error("element_value: expected %0d, got %0d",
                   $signed(want.value), $signed(m_tdata[31:0]));
            error_count++;
          end
          if (m_tdata[36:32] !== want.pos) begin
            $error("element_position: expected %0d, got %0d", want.pos, m_tdata[36:32]);
            error_count++;
          end
          if (m_tlast !== want.last) begin
            $error("is_last: expected %0d, got %0d", want.last, m_tlast);
            error_count++;
          end
          if (m_tuser[0] !== want.empty) begin
            $error("list_empty: expected %0d, got %0d", want.empty, m_tuser[0]);
            error_count++;
          end
          if (m_tuser[1] !== want.ovf) begin
            $error("overflowed: expected %0d, got %0d", want.ovf, m_tuser[1]);
            error_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hang detector: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("multi_list_append_dump_clear verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_op(input logic [1:0] command, input logic [3:0] index,
                          input logic [31:0] value);
    list_op_t op;
    op.command = command;
    op.index   = index;
    op.value   = value;
    pending_ops_q.insert(pending_ops_q.size(), op);
  endtask

  // Wait until every command is out and every result back, then give the
  // pipeline time to retire trailing pushes/clears.
  task automatic wait_idle();
    while (pending_ops_q.size() > 0 || s_tvalid || dump_expect_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_lists_in_use(input logic [4:0] count);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    active_lists = count;
  endtask

  // Traffic built from well-formed runs: a burst of pushes to one list,
  // then usually a dump, sometimes a clear or the reserved code. One burst
  // in six can fill a list past capacity. About one target in ten is drawn
  // from the whole index range, so some runs land on unaddressed lists.
  task automatic queue_random_traffic(input int op_budget);
    int          issued;
    int          burst;
    int          pick;
    logic [3:0]  target;
    logic [31:0] v;
    issued = 0;
    while (issued < op_budget) begin
      if ($urandom_range(9) == 0) target = 4'($urandom_range(15));
      else target = 4'($urandom_range(active_lists - 1));
      burst = ($urandom_range(5) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 6);
      for (int n = 0; n < burst; n++) begin
        case ($urandom_range(7))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = '0;
          3:       v = '1;
          default: v = $urandom();
        endcase
        queue_op(mldc_pkg::CMD_PUSH, target, v);
      end
      pick = $urandom_range(99);
      if (pick < 60)      queue_op(mldc_pkg::CMD_DUMP, target, $urandom());
      else if (pick < 75) queue_op(mldc_pkg::CMD_CLEAR, target, $urandom());
      else if (pick < 85) queue_op(CMD_RESERVED, target, $urandom());
      issued += burst + 1;
    end
  endtask

  initial begin
    foreach (fill_count[i]) begin
      fill_count[i]    = 0;
      overflow_seen[i] = 1'b0;
    end
    send_idle_pct = 38;
    recv_idle_pct = 74;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dumps, value extremes at both ends of the index range,
    // reserved command, clear of an empty list, single-element dump.
    queue_op(mldc_pkg::CMD_DUMP,  4'd0,  '0);
    queue_op(mldc_pkg::CMD_PUSH,  4'd0,  32'h8000_0000);
    queue_op(mldc_pkg::CMD_PUSH,  4'd0,  32'h7FFF_FFFF);
    queue_op(mldc_pkg::CMD_PUSH,  4'd0,  32'h0000_0000);
    queue_op(mldc_pkg::CMD_PUSH,  4'd15, 32'hFFFF_FFFF);
    queue_op(mldc_pkg::CMD_PUSH,  4'd15, 32'h5555_5555);
    queue_op(mldc_pkg::CMD_PUSH,  4'd15, 32'hAAAA_AAAA);
    queue_op(mldc_pkg::CMD_DUMP,  4'd0,  '1);
    queue_op(mldc_pkg::CMD_DUMP,  4'd15, '0);
    queue_op(CMD_RESERVED,        4'd0,  32'h1234_5678);
    queue_op(CMD_RESERVED,        4'd15, '1);
    queue_op(mldc_pkg::CMD_CLEAR, 4'd0,  '1);
    queue_op(mldc_pkg::CMD_DUMP,  4'd0,  '0);
    queue_op(mldc_pkg::CMD_PUSH,  4'd0,  32'h0000_0001);
    queue_op(mldc_pkg::CMD_DUMP,  4'd0,  '0);
    queue_op(mldc_pkg::CMD_CLEAR, 4'd15, '0);
    queue_op(mldc_pkg::CMD_CLEAR, 4'd15, '0);
    queue_op(mldc_pkg::CMD_DUMP,  4'd15, '0);
    queue_op(mldc_pkg::CMD_PUSH,  4'd7,  $urandom());
    queue_op(mldc_pkg::CMD_DUMP,  4'd7,  '0);
    wait_idle();

    // One list live: long bursts overflow it, all else is ignored.
    write_lists_in_use(5'd1);
    queue_random_traffic(140);
    wait_idle();

    // All lists live, backpressure pattern swapped.
    send_idle_pct = 74;
    recv_idle_pct = 38;
    write_lists_in_use(5'd16);
    queue_random_traffic(130);
    wait_idle();

    // Mid-range setting at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_lists_in_use(5'($urandom_range(2, 15)));
    queue_random_traffic(130);
    wait_idle();

    if (dump_expect_q.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("multi_list_append_dump_clear verification clean");
    end else begin
      $display("multi_list_append_dump_clear verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mldc_pkg.sv
src/mldc_elem_ram.sv
src/mldc_out_fifo.sv
src/multi_list_append_dump_clear.sv
tb/multi_list_append_dump_clear_test.sv
